### sv/rufc_pkg.sv
package rufc_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_COMMA = 8'd44;

    // Depth of the command queue between parser and serializer
    localparam int QDEPTH = 4;

    // Index of the units digit in the five-digit decimal form
    localparam logic [2:0] DIGIT_UNITS    = 3'd4;
    localparam logic [2:0] DIGIT_HUNDREDS = 3'd2;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_T0_HDR = 2'd0;  // byte 1 + three count digits
    localparam t_kind KIND_T0_NUM = 2'd1;  // decimal number, comma unless record done
    localparam t_kind KIND_T1_HDR = 2'd2;  // byte 0 + count low byte
    localparam t_kind KIND_T1_NUM = 2'd3;  // 16-bit big-endian number

    // One command per input transfer that produces output bytes
    typedef struct packed {
        t_kind       kind;
        logic [15:0] val;
        logic [2:0]  start;  // first decimal digit shown (leading zeros skipped)
        logic        done;   // record completes with this command
        logic        extra;  // append a zero number (two zero bytes) ending the record
    } t_cmd;

    // k times the weight of decimal digit idx (idx 0 is ten-thousands)
    function automatic logic [16:0] dec_weight(logic [2:0] idx, logic [3:0] k);
        logic [16:0] w;
        logic [33:0] p;
        unique case (idx)
            3'd0:    w = 17'd10000;
            3'd1:    w = 17'd1000;
            3'd2:    w = 17'd100;
            3'd3:    w = 17'd10;
            default: w = 17'd1;
        endcase
        p = w * {13'd0, k};
        return p[16:0];
    endfunction

    // First significant digit position of a 16-bit value
    function automatic logic [2:0] start_digit(logic [15:0] v);
        logic [2:0] s;
        priority if (v >= 16'd10000) s = 3'd0;
        else if (v >= 16'd1000)      s = 3'd1;
        else if (v >= 16'd100)       s = 3'd2;
        else if (v >= 16'd10)        s = 3'd3;
        else                         s = DIGIT_UNITS;
        return s;
    endfunction

endpackage

### sv/rufc_front.sv
module rufc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_in_byte,
    input  logic           i_stream_end,
    output logic           o_cmd_push,
    output rufc_pkg::t_cmd o_cmd
);
    import rufc_pkg::*;

    localparam logic [2:0] MODE_WAIT     = 3'd0;
    localparam logic [2:0] MODE_T0_COUNT = 3'd1;
    localparam logic [2:0] MODE_T0_HIGH  = 3'd2;
    localparam logic [2:0] MODE_T0_LOW   = 3'd3;
    localparam logic [2:0] MODE_T1_COUNT = 3'd4;
    localparam logic [2:0] MODE_T1_NUM   = 3'd5;

    logic [2:0]  r_mode, n_mode;
    logic [9:0]  r_left, n_left;
    logic [9:0]  r_cnt,  n_cnt;
    logic [1:0]  r_didx, n_didx;
    logic [7:0]  r_hold, n_hold;
    logic [15:0] r_num,  n_num;

    logic        push_c;
    t_cmd        cmd_c;
    logic [9:0]  left_dec;
    logic [9:0]  cnt_new;
    logic [1:0]  didx_new;
    logic [15:0] num_new;
    logic [15:0] v;

    always_comb begin
        n_mode   = r_mode;
        n_left   = r_left;
        n_cnt    = r_cnt;
        n_didx   = r_didx;
        n_hold   = r_hold;
        n_num    = r_num;
        push_c   = 1'b0;
        cmd_c    = '0;
        left_dec = r_left - 10'd1;
        cnt_new  = r_cnt * 10'd10 + {2'b00, i_in_byte} - 10'd48;
        didx_new = r_didx + 2'd1;
        num_new  = r_num * 16'd10 + {8'h00, i_in_byte} - 16'd48;
        v        = {r_hold, i_in_byte};

        unique case (r_mode)
            MODE_T0_COUNT: begin
                push_c     = 1'b1;
                cmd_c.kind = KIND_T0_HDR;
                cmd_c.val  = {8'h00, i_in_byte};
                cmd_c.done = (i_in_byte == 8'd0);
                n_left     = {2'b00, i_in_byte};
                n_mode     = (i_in_byte == 8'd0) ? MODE_WAIT : MODE_T0_HIGH;
            end
            MODE_T0_HIGH: begin
                n_hold = i_in_byte;
                n_mode = MODE_T0_LOW;
            end
            MODE_T0_LOW: begin
                push_c      = 1'b1;
                cmd_c.kind  = KIND_T0_NUM;
                cmd_c.val   = v;
                cmd_c.start = start_digit(v);
                cmd_c.done  = (left_dec == 10'd0);
                n_left      = left_dec;
                n_mode      = (left_dec == 10'd0) ? MODE_WAIT : MODE_T0_HIGH;
            end
            MODE_T1_COUNT: begin
                n_cnt = cnt_new;
                if (didx_new == 2'd3) begin
                    n_didx     = 2'd0;
                    n_left     = cnt_new;
                    n_num      = 16'd0;
                    push_c     = 1'b1;
                    cmd_c.kind = KIND_T1_HDR;
                    cmd_c.val  = {8'h00, cnt_new[7:0]};
                    cmd_c.done = (cnt_new == 10'd0);
                    n_mode     = (cnt_new == 10'd0) ? MODE_WAIT : MODE_T1_NUM;
                end else begin
                    n_didx = didx_new;
                end
            end
            MODE_T1_NUM: begin
                if (i_in_byte == 8'd0 || i_in_byte == 8'd1) begin
                    // type byte cuts the record short and opens the next one
                    push_c     = 1'b1;
                    cmd_c.kind = KIND_T1_NUM;
                    cmd_c.val  = r_num;
                    cmd_c.done = 1'b1;
                    n_left     = left_dec;
                    n_num      = 16'd0;
                    if (i_in_byte == 8'd0) begin
                        n_mode = MODE_T0_COUNT;
                    end else begin
                        n_mode = MODE_T1_COUNT;
                        n_didx = 2'd0;
                        n_cnt  = 10'd0;
                    end
                end else if (i_in_byte == CHAR_COMMA) begin
                    push_c     = 1'b1;
                    cmd_c.kind = KIND_T1_NUM;
                    cmd_c.val  = r_num;
                    cmd_c.done = (left_dec == 10'd0);
                    n_left     = left_dec;
                    n_num      = 16'd0;
                    n_mode     = (left_dec == 10'd0) ? MODE_WAIT : MODE_T1_NUM;
                end else begin
                    n_num = num_new;
                end
            end
            default: begin
                if (i_in_byte == 8'd0) begin
                    n_mode = MODE_T0_COUNT;
                end else if (i_in_byte == 8'd1) begin
                    n_mode = MODE_T1_COUNT;
                    n_didx = 2'd0;
                    n_cnt  = 10'd0;
                end
            end
        endcase

        if (i_stream_end) begin
            // flush an open type 1 number; the pending value is zero when a
            // command was already made for this byte
            if (n_mode == MODE_T1_NUM && n_left != 10'd0) begin
                if (push_c) begin
                    cmd_c.extra = 1'b1;
                end else begin
                    push_c     = 1'b1;
                    cmd_c.kind = KIND_T1_NUM;
                    cmd_c.val  = n_num;
                    cmd_c.done = 1'b1;
                end
            end
            n_mode = MODE_WAIT;
            n_left = 10'd0;
            n_cnt  = 10'd0;
            n_didx = 2'd0;
            n_hold = 8'd0;
            n_num  = 16'd0;
        end
    end

    assign o_cmd_push = i_accept && push_c;
    assign o_cmd      = cmd_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_WAIT;
            r_left <= 10'd0;
            r_cnt  <= 10'd0;
            r_didx <= 2'd0;
            r_hold <= 8'd0;
            r_num  <= 16'd0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_left <= n_left;
            r_cnt  <= n_cnt;
            r_didx <= n_didx;
            r_hold <= n_hold;
            r_num  <= n_num;
        end
    end

endmodule

### sv/rufc_queue.sv
module rufc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rufc_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_take,
    output rufc_pkg::t_cmd o_cmd,
    output logic           o_valid
);
    import rufc_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_cmd          r_mem [QDEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_take;

    assign o_full  = (r_cnt == CW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_take = i_take && o_valid;

    always_comb begin
        n_wp = (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + PW'(1);
        n_rp = (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + PW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= n_wp;
            if (do_take) r_rp <= n_rp;
            if (do_push && !do_take) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_take && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_cmd;
    end

endmodule

### sv/rufc_back.sv
module rufc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rufc_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_take,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last,
    output logic           o_record_done
);
    import rufc_pkg::*;

    localparam logic [2:0] PH_LEAD = 3'd0;
    localparam logic [2:0] PH_DIG  = 3'd1;
    localparam logic [2:0] PH_TAIL = 3'd2;
    localparam logic [2:0] PH_X0   = 3'd3;
    localparam logic [2:0] PH_X1   = 3'd4;

    logic        r_act;
    t_cmd        r_cmd;
    logic [2:0]  r_ph, n_ph;
    logic [2:0]  r_idx, n_idx;
    logic [15:0] n_val;

    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_olast;
    logic        r_odone;

    logic [3:0]  dig;
    logic [16:0] sub;
    logic [7:0]  byte_c;
    logic        done_c;
    logic        last_c;
    logic        is_units;
    logic        load_out;
    logic        finish;

    // digit of the current position: largest k with k * weight <= remainder
    always_comb begin
        dig = 4'd0;
        sub = 17'd0;
        for (int k = 1; k < 10; k++) begin
            if ({1'b0, r_cmd.val} >= dec_weight(r_idx, 4'(k))) begin
                dig = 4'(k);
                sub = dec_weight(r_idx, 4'(k));
            end
        end
    end

    always_comb begin
        byte_c   = 8'h00;
        done_c   = 1'b0;
        last_c   = 1'b0;
        n_ph     = r_ph;
        n_idx    = r_idx;
        n_val    = r_cmd.val;
        is_units = (r_idx == DIGIT_UNITS);
        unique case (r_ph)
            PH_LEAD: begin
                unique case (r_cmd.kind)
                    KIND_T0_HDR: byte_c = 8'd1;
                    KIND_T1_NUM: byte_c = r_cmd.val[15:8];
                    default:     byte_c = 8'd0;
                endcase
                n_ph = (r_cmd.kind == KIND_T0_HDR) ? PH_DIG : PH_TAIL;
            end
            PH_DIG: begin
                byte_c = CHAR_ZERO + {4'h0, dig};
                done_c = is_units && r_cmd.done;
                last_c = is_units && (r_cmd.kind == KIND_T0_HDR || r_cmd.done);
                n_val  = r_cmd.val - sub[15:0];
                n_idx  = r_idx + 3'd1;
                n_ph   = is_units ? PH_TAIL : PH_DIG;
            end
            PH_TAIL: begin
                if (r_cmd.kind == KIND_T0_NUM) begin
                    byte_c = CHAR_COMMA;
                    last_c = 1'b1;
                end else begin
                    byte_c = r_cmd.val[7:0];
                    done_c = r_cmd.done;
                    last_c = !r_cmd.extra;
                end
                n_ph = PH_X0;
            end
            PH_X0: begin
                n_ph = PH_X1;
            end
            PH_X1: begin
                done_c = 1'b1;
                last_c = 1'b1;
            end
            default: begin
                last_c = 1'b1;
            end
        endcase
    end

    assign load_out   = r_act && (!r_ovalid || i_pop);
    assign finish     = load_out && last_c;
    assign o_cmd_take = i_cmd_valid && (!r_act || finish);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= 1'b0;
            r_ph     <= PH_LEAD;
            r_idx    <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_cmd_take) begin
                r_act <= 1'b1;
                r_ph  <= (i_cmd.kind == KIND_T0_NUM) ? PH_DIG : PH_LEAD;
                r_idx <= (i_cmd.kind == KIND_T0_HDR) ? DIGIT_HUNDREDS : i_cmd.start;
            end else if (finish) begin
                r_act <= 1'b0;
            end else if (load_out) begin
                r_ph  <= n_ph;
                r_idx <= n_idx;
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end else if (load_out) begin
            r_cmd.val <= n_val;
        end
        if (load_out) begin
            r_obyte <= byte_c;
            r_olast <= last_c;
            r_odone <= done_c;
        end
    end

    assign o_empty       = !r_ovalid;
    assign o_out_byte    = r_obyte;
    assign o_run_last    = r_olast;
    assign o_record_done = r_odone;

endmodule

### sv/record_unit_format_converter.sv
// Record format converter: a byte stream of records goes in, the converted
// byte stream comes out.
//
// Input channel (push/full): one byte per transfer with i_stream_end marking
// the final byte. The parser takes a byte in every cycle while full is low.
// Output channel (empty/pop): one converted byte per transfer, with
// o_run_last on the last byte caused by one input byte and o_record_done on
// the byte that closes a converted record.
//
// Structure: the parser classifies each input byte and, when it causes
// output, writes one command into a 4-entry queue. The serializer expands
// each command into 1 to 6 bytes, one byte per cycle while the receiver
// pops, computing decimal digits one position a cycle, into an output
// register. An input byte's command is registered in the queue, then
// taken into the serializer, whose bytes pass the output register.
// Throughput: one output byte per cycle while the receiver pops; the
// serializer takes the next command along with the last byte of the current one.
// Reset clears parser state, queue and output register; no clearing pass.
// When the receiver stops popping, the output register holds, the
// serializer waits, the queue fills and full rises; no byte is lost.
module record_unit_format_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_stream_end,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_record_done
);
    import rufc_pkg::*;

    logic accept;
    logic cmd_push;
    t_cmd cmd_in;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic q_take;

    // an input byte transfers when the queue has room for its command
    assign full   = q_full;
    assign accept = push && !q_full;

    rufc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_in_byte    (i_in_byte),
        .i_stream_end (i_stream_end),
        .o_cmd_push   (cmd_push),
        .o_cmd        (cmd_in)
    );

    rufc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .i_take  (q_take),
        .o_cmd   (q_cmd),
        .o_valid (q_valid)
    );

    rufc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (q_cmd),
        .i_cmd_valid   (q_valid),
        .o_cmd_take    (q_take),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_record_done (o_record_done)
    );

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

// Checks the record format converter against a cycle-free predictor.
// Input bytes go in over push/full, converted bytes come out over empty/pop.
// Every accepted input byte is run through the predictor, which appends the
// bytes it should cause to a queue; each output transfer is compared with
// the head of that queue.
module testbench;
    import rufc_pkg::*;

    // Watchdog: cycles in a row with no transfer on either side
    localparam int STALL_LIMIT = 2000;
    // Quiet cycles after the last expected byte, to catch stray output
    localparam int TAIL_CYCLES = 16;
    localparam int POW10 [5] = '{10000, 1000, 100, 10, 1};

    // Parser position within the record stream
    localparam logic [2:0] PM_IDLE      = 3'd0;  // waiting for a type byte
    localparam logic [2:0] PM_BIN_COUNT = 3'd1;  // binary record: count byte next
    localparam logic [2:0] PM_BIN_HIGH  = 3'd2;  // binary record: high byte next
    localparam logic [2:0] PM_BIN_LOW   = 3'd3;  // binary record: low byte next
    localparam logic [2:0] PM_TXT_COUNT = 3'd4;  // text record: count digits
    localparam logic [2:0] PM_TXT_NUM   = 3'd5;  // text record: decimal numbers

    // One converted output byte as the predictor expects it
    typedef struct {
        logic [7:0] value;
        logic       last;
        logic       done;
    } t_out_byte;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       push         = 1'b0;
    logic       full;
    logic [7:0] i_in_byte    = 8'd0;
    logic       i_stream_end = 1'b0;
    logic       empty;
    logic       pop          = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_run_last;
    logic       o_record_done;

    // Idle and stall rates in percent, changed per test phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int mismatches  = 0;
    int items_taken = 0;   // input transfers that the parser acts on
    int bytes_seen  = 0;   // output transfers so far
    int quiet_cycles = 0;

    // Predictor state
    logic [2:0]  mode         = PM_IDLE;
    logic [9:0]  numbers_left = '0;
    logic [9:0]  count_acc    = '0;
    logic [1:0]  digit_idx    = '0;
    logic [7:0]  high_hold    = '0;
    logic [15:0] number_acc   = '0;
    int          step_count   = 0;

    t_out_byte converted_bytes [$];

    record_unit_format_converter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_in_byte     (i_in_byte),
        .i_stream_end  (i_stream_end),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_record_done (o_record_done)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] value, input logic done);
        converted_bytes.push_back('{value, 1'b0, done});
        step_count++;
    endtask

    task automatic clear_parser();
        mode         = PM_IDLE;
        numbers_left = '0;
        count_acc    = '0;
        digit_idx    = '0;
        high_hold    = '0;
        number_acc   = '0;
    endtask

    // Pending text number goes out as two big-endian bytes
    task automatic flush_text_number(input logic force_done);
        logic done;
        numbers_left = numbers_left - 10'd1;
        done = (numbers_left == 0) || force_done;
        queue_byte(number_acc[15:8], 1'b0);
        queue_byte(number_acc[7:0], done);
        number_acc = '0;
        if (done) begin
            mode = PM_IDLE;
        end
    endtask

    // A type byte opens a record; anything else is dropped
    task automatic open_record(input logic [7:0] b);
        if (b == 8'd0) begin
            mode = PM_BIN_COUNT;
        end else if (b == 8'd1) begin
            mode      = PM_TXT_COUNT;
            digit_idx = '0;
            count_acc = '0;
        end
    endtask

    // Works out the bytes caused by one accepted input byte
    task automatic convert_byte(input logic [7:0] b, input logic eos);
        int   v;
        int   d;
        logic started;
        logic done;
        step_count = 0;
        if (mode != PM_IDLE || b <= 8'd1) begin
            items_taken++;
        end
        case (mode)
            PM_BIN_COUNT: begin
                queue_byte(8'd1, 1'b0);
                queue_byte(8'(CHAR_ZERO + b / 100), 1'b0);
                queue_byte(8'(CHAR_ZERO + (b / 10) % 10), 1'b0);
                queue_byte(8'(CHAR_ZERO + b % 10), b == 8'd0);
                numbers_left = {2'b00, b};
                mode = (b == 8'd0) ? PM_IDLE : PM_BIN_HIGH;
            end
            PM_BIN_HIGH: begin
                high_hold = b;
                mode      = PM_BIN_LOW;
            end
            PM_BIN_LOW: begin
                v = int'({high_hold, b});
                numbers_left = numbers_left - 10'd1;
                done    = (numbers_left == 0);
                started = 1'b0;
                // decimal digits, leading zeros suppressed, units always shown
                for (int k = 0; k < 5; k++) begin
                    d = (v / POW10[k]) % 10;
                    if (d != 0 || started || k == 4) begin
                        started = 1'b1;
                        queue_byte(8'(CHAR_ZERO + d), (k == 4) && done);
                    end
                end
                if (done) begin
                    mode = PM_IDLE;
                end else begin
                    queue_byte(CHAR_COMMA, 1'b0);
                    mode = PM_BIN_HIGH;
                end
            end
            PM_TXT_COUNT: begin
                count_acc = 10'(count_acc * 10 + b - CHAR_ZERO);   // wraps at 10 bits
                digit_idx = digit_idx + 2'd1;
                if (digit_idx == 2'd3) begin
                    digit_idx    = '0;
                    numbers_left = count_acc;
                    number_acc   = '0;
                    queue_byte(8'd0, 1'b0);
                    queue_byte(count_acc[7:0], count_acc == 0);
                    mode = (count_acc == 0) ? PM_IDLE : PM_TXT_NUM;
                end
            end
            PM_TXT_NUM: begin
                if (b <= 8'd1) begin
                    // short record: a new type byte closes it
                    flush_text_number(1'b1);
                    open_record(b);
                end else if (b == CHAR_COMMA) begin
                    flush_text_number(1'b0);
                end else begin
                    number_acc = 16'(number_acc * 10 + b - CHAR_ZERO);
                end
            end
            default: begin
                open_record(b);
            end
        endcase
        if (eos) begin
            // stream end flushes an open text record, drops anything else
            if (mode == PM_TXT_NUM && numbers_left != 0) begin
                flush_text_number(1'b1);
            end
            clear_parser();
        end
        if (step_count > 0) begin
            converted_bytes[$].last = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random pop, compare at the falling edge
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("mismatch at output byte %0d: %s got 0x%0h, want 0x%0h",
                 bytes_seen, field, got, want);
        mismatches++;
    endtask

    // Signals are stable at the falling edge, so a pop seen here is the
    // transfer that the next rising edge completes.
    always @(negedge i_clk) begin
        t_out_byte want;
        if (i_rst_n && pop && !empty) begin
            if (converted_bytes.size() == 0) begin
                report_mismatch("unexpected out_byte", int'(o_out_byte), 0);
            end else begin
                want = converted_bytes.pop_front();
                if (o_out_byte !== want.value) begin
                    report_mismatch("out_byte", int'(o_out_byte), int'(want.value));
                end
                if (o_run_last !== want.last) begin
                    report_mismatch("run_last", int'(o_run_last), int'(want.last));
                end
                if (o_record_done !== want.done) begin
                    report_mismatch("record_done", int'(o_record_done),
                                    int'(want.done));
                end
            end
            bytes_seen++;
        end
    end

    // Watchdog: ends the run when neither side moves for too long
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Sends one byte; returns right after the edge that takes it. The
    // predictor runs at the falling edge just before that transfer.
    task automatic send_byte(input logic [7:0] value, input logic eos);
        logic was_full;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_in_byte    <= value;
        i_stream_end <= eos;
        do begin
            @(negedge i_clk);
            was_full = full;
            if (!was_full) begin
                convert_byte(value, eos);
            end
            @(posedge i_clk);
        end while (was_full);
    endtask

    // Occasional stream end inside otherwise well-formed records
    function automatic logic rare_end();
        return $urandom_range(0, 59) == 0;
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 9));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Binary record: type 0, count byte, big-endian numbers; sometimes cut short
    task automatic send_binary_record();
        int count;
        int pairs;
        logic [15:0] w;
        case ($urandom_range(0, 9))
            0:       count = 0;
            1:       count = $urandom_range(6, 24);
            default: count = $urandom_range(1, 4);
        endcase
        pairs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, count) : count;
        send_byte(8'd0, rare_end());
        send_byte(8'(count), rare_end());
        for (int k = 0; k < pairs; k++) begin
            w = pick_word();
            send_byte(w[15:8], rare_end());
            send_byte(w[7:0], rare_end());
        end
    endtask

    // Digit byte, now and then a stray non-digit that is not a type byte or comma
    function automatic logic [7:0] pick_digit();
        if ($urandom_range(0, 29) == 0) begin
            return 8'($urandom_range(58, 255));
        end
        return 8'(CHAR_ZERO + $urandom_range(0, 9));
    endfunction

    // Text record: type 1, three count digits, comma-separated decimals.
    // Large counts are always cut short so that they stay cheap.
    task automatic send_text_record();
        int count;
        int nums;
        int digits;
        count = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 999)
                                             : $urandom_range(0, 6);
        if (count > 12 || $urandom_range(0, 6) == 0) begin
            nums = $urandom_range(0, (count > 4) ? 4 : count);
        end else begin
            nums = count;
        end
        send_byte(8'd1, rare_end());
        send_byte(($urandom_range(0, 19) == 0) ? pick_digit()
                                               : 8'(CHAR_ZERO + count / 100),
                  rare_end());
        send_byte(8'(CHAR_ZERO + (count / 10) % 10), rare_end());
        send_byte(8'(CHAR_ZERO + count % 10), rare_end());
        for (int k = 0; k < nums; k++) begin
            digits = $urandom_range(0, 6);   // six digits wrap past 16 bits
            repeat (digits) begin
                send_byte(pick_digit(), rare_end());
            end
            // last number may be left open for the next type byte to close
            if (k < nums - 1 || $urandom_range(0, 1) == 1) begin
                send_byte(CHAR_COMMA, rare_end());
            end
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4)) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Bytes other than 0 or 1 between records are dropped
    task automatic test_other_type_bytes();
        send_byte(8'd7, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // Empty binary record, then one holding the extreme numbers
    task automatic test_binary_records();
        send_byte(8'd0, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'd2, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // Top count with stream end on it: header out, rest of record dropped
    task automatic test_binary_cut_by_end();
        send_byte(8'd0, 1'b0);
        send_byte(8'd255, 1'b1);
    endtask

    // Text record closed early by a type byte before any digit, then an
    // empty text record
    task automatic test_text_short_and_empty();
        send_byte(8'd1, 1'b0);
        send_byte(CHAR_ZERO, 1'b0);
        send_byte(CHAR_ZERO, 1'b0);
        send_byte(CHAR_ZERO + 8'd2, 1'b0);
        send_byte(8'd1, 1'b0);
        send_byte(CHAR_ZERO, 1'b0);
        send_byte(CHAR_ZERO, 1'b0);
        send_byte(CHAR_ZERO, 1'b0);
    endtask

    // Count 999 (only low byte shown), a non-digit number char, and stream
    // end flushing the pending number
    task automatic test_text_flush_at_end();
        send_byte(8'd1, 1'b0);
        send_byte(CHAR_ZERO + 8'd9, 1'b0);
        send_byte(CHAR_ZERO + 8'd9, 1'b0);
        send_byte(CHAR_ZERO + 8'd9, 1'b0);
        send_byte(8'd58, 1'b1);
    endtask

    // Mostly well-formed records with random content, some noise
    task automatic test_random_stream(input int idle_pct, input int stall_pct,
                                      input int target);
        int start;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = items_taken;
        while (items_taken - start < target) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_binary_record();
                5, 6, 7, 8:    send_text_record();
                default:       send_noise();
            endcase
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_other_type_bytes();
        test_binary_records();
        test_binary_cut_by_end();
        test_text_short_and_empty();
        test_text_flush_at_end();

        test_random_stream(0, 0, 100);
        test_random_stream(71, 0, 100);
        test_random_stream(0, 71, 100);
        test_random_stream(7, 7, 100);

        push <= 1'b0;
        recv_stall_pct = 0;
        // watchdog ends the run if bytes go missing
        while (converted_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
sv/rufc_pkg.sv
sv/rufc_front.sv
sv/rufc_queue.sv
sv/rufc_back.sv
sv/record_unit_format_converter.sv
dv/testbench.sv
